/* rtl/core/j1939_tp_receiver_macros.svh */
// Assertion macros shared by the receiver RTL.
// Each use names a label, an antecedent and a consequent; clk and rst_n
// are taken from the module in which the macro is used.
`ifndef J1939_TP_RECEIVER_MACROS_SVH
`define J1939_TP_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

`define JTP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define JTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define JTP_ASSERT_SAME(lbl, ante, cons)

`define JTP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/jtp_pkg.sv */
package jtp_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_FRAME = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] KIND_TX      = 3'd0;
    localparam logic [2:0] KIND_FRAME   = 3'd1;
    localparam logic [2:0] KIND_CHUNK   = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;
    localparam logic [2:0] KIND_SEQ_ERR = 3'd5;

    localparam logic [1:0] CFG_ECU_ADDR      = 2'd0;
    localparam logic [1:0] CFG_TOOL_ADDR     = 2'd1;
    localparam logic [1:0] CFG_LISTEN_FIRST  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic [7:0] PF_ACK  = 8'hE8;
    localparam logic [7:0] PF_CM   = 8'hEC;
    localparam logic [7:0] PF_DT   = 8'hEB;
    localparam logic [7:0] PF_REQ  = 8'hEA;
    localparam logic [7:0] ID_PRIO_REQ = 8'h98;
    localparam logic [7:0] ID_PRIO_CM  = 8'h9C;
    localparam logic [7:0] CTL_BAM = 8'h20;
    localparam logic [7:0] CTL_RTS = 8'h10;
    localparam logic [7:0] CTL_CTS = 8'h11;
    localparam logic [7:0] CTL_EOM = 8'h13;

    typedef struct packed {
        logic [7:0]  ecu_addr;
        logic [7:0]  tool_addr;
        logic        listen_first;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [17:0] pgn;
        logic [7:0]  id_page_byte;
        logic [7:0]  pdu_format;
        logic [7:0]  pdu_specific;
        logic [7:0]  source_addr;
        logic [63:0] rx_data;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] frame_id;
        logic [63:0] frame_data;
        logic [2:0]  byte_count;
    } result_t;

    typedef struct packed {
        logic [1:0]          cnt;
        result_t [2:0]       res;
    } bundle_t;

endpackage

/* rtl/core/j1939_tp_receiver.sv */
// Requester side of a J1939 parameter-group fetch over transport protocol.
// Input channel (in_valid/in_ready): mode 0 starts a fetch of pgn, mode 1
// carries a received CAN frame, mode 2 is one timer tick.
// Output channel (out_valid/out_ready): result items (transmit frame, whole
// response, payload chunk, done, timeout, sequence error); last marks the
// final result caused by one input item.
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects ecu_addr,
// tool_addr, listen_first or timeout_ticks; always ready; write when idle.
// Each item is held in the input register, and its results in the result register.
// Throughput: one item per cycle while out_ready is high and each item
// gives at most one result; an item with k results holds the output until
// all k are taken, one result per cycle while out_ready is high.
// Reset clears the fetch to idle and loads the register defaults; no fetch
// runs until a start item arrives.
// When out_ready is low the result register holds; one further item waits in
// the input register, and items that give no result keep flowing.
`include "j1939_tp_receiver_macros.svh"

module j1939_tp_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [17:0] pgn,
    input  logic [7:0]  id_page_byte,
    input  logic [7:0]  pdu_format,
    input  logic [7:0]  pdu_specific,
    input  logic [7:0]  source_addr,
    input  logic [63:0] rx_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [31:0] frame_id,
    output logic [63:0] frame_data,
    output logic [2:0]  byte_count,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    jtp_pkg::cfg_t    cfg_reg;
    jtp_pkg::item_t   s1_item_reg;
    logic             s1_valid_reg;
    jtp_pkg::bundle_t s2_bundle_reg;
    logic             s2_valid_reg;
    logic [1:0]       s2_idx_reg;
    jtp_pkg::bundle_t bundle;
    jtp_pkg::result_t cur;
    logic             out_xfer, s2_free, s1_advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ecu_addr      <= 8'd255;
            cfg_reg.tool_addr     <= 8'd254;
            cfg_reg.listen_first  <= 1'b1;
            cfg_reg.timeout_ticks <= 16'd2000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jtp_pkg::CFG_ECU_ADDR:      cfg_reg.ecu_addr      <= cfg_data[7:0];
                jtp_pkg::CFG_TOOL_ADDR:     cfg_reg.tool_addr     <= cfg_data[7:0];
                jtp_pkg::CFG_LISTEN_FIRST:  cfg_reg.listen_first  <= cfg_data[0];
                jtp_pkg::CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    jtp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .item    (s1_item_reg),
        .advance (s1_advance),
        .bundle  (bundle)
    );

    always_comb
    begin
        case (s2_idx_reg)
            2'd1:    cur = s2_bundle_reg.res[1];
            2'd2:    cur = s2_bundle_reg.res[2];
            default: cur = s2_bundle_reg.res[0];
        endcase
    end

    assign out_valid  = s2_valid_reg;
    assign kind       = cur.kind;
    assign frame_id   = cur.frame_id;
    assign frame_data = cur.frame_data;
    assign byte_count = cur.byte_count;
    assign last       = (s2_idx_reg == s2_bundle_reg.cnt - 2'd1);

    assign out_xfer   = out_valid && out_ready;
    assign s2_free    = !s2_valid_reg || (out_xfer && last);
    assign s1_advance = s1_valid_reg && (bundle.cnt == 2'd0 || s2_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // hold the transfer until the engine has taken the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= '{mode: mode, pgn: pgn, id_page_byte: id_page_byte,
                             pdu_format: pdu_format, pdu_specific: pdu_specific,
                             source_addr: source_addr, rx_data: rx_data};
        end
    end

    // load a new bundle, or advance through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_idx_reg   <= 2'd0;
        end
        else if (s1_advance && bundle.cnt != 2'd0)
        begin
            s2_valid_reg <= 1'b1;
            s2_idx_reg   <= 2'd0;
        end
        else if (out_xfer)
        begin
            if (last)
            begin
                s2_valid_reg <= 1'b0;
                s2_idx_reg   <= 2'd0;
            end
            else
            begin
                s2_idx_reg <= s2_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && bundle.cnt != 2'd0)
        begin
            s2_bundle_reg <= bundle;
        end
    end

    `JTP_ASSERT_SAME(a_idx_in_bundle, s2_valid_reg, s2_idx_reg < s2_bundle_reg.cnt)
    `JTP_ASSERT_SAME(a_idle_idx_zero, !s2_valid_reg, s2_idx_reg == 2'd0)
    `JTP_ASSERT_NEXT(a_bundle_restart, out_xfer && last, !s2_valid_reg || s2_idx_reg == 2'd0)
    `JTP_ASSERT_SAME(a_free_input, !s1_valid_reg, in_ready)

endmodule

/* rtl/core/jtp_engine.sv */
module jtp_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  jtp_pkg::cfg_t   cfg,
    input  jtp_pkg::item_t  item,
    input  logic            advance,
    output jtp_pkg::bundle_t bundle
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_BAM  = 2'd2;
    localparam logic [1:0] PH_RTS  = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [17:0] wanted_reg, wanted_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  pkt_total_reg, pkt_total_next;
    logic [7:0]  next_seq_reg, next_seq_next;
    logic        req_sent_reg, req_sent_next;
    logic [15:0] tick_reg, tick_next;
    logic [2:0]  last_cnt_reg, last_cnt_next;

    function automatic logic [2:0] mod7(input logic [15:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        begin
            s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
               + 6'(v[14:12]) + 6'(v[15]);
            s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
            mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
        end
    endfunction

    jtp_pkg::result_t req_res, cts_res, eom_res, chunk_res, done_res, tmo_res;
    jtp_pkg::result_t err_res, frame_res;
    logic [31:0] cm_id, fid;
    logic [63:0] grp64;
    logic [16:0] ann_grp;
    logic [16:0] own_grp;
    logic [7:0]  ctl, np, seq;
    logic [15:0] tick_inc;
    logic [2:0]  n_bytes, ann_mod;
    logic        fin;
    logic [63:0] chunk;

    always_comb
    begin
        cm_id   = {jtp_pkg::ID_PRIO_CM, jtp_pkg::PF_CM, cfg.ecu_addr, cfg.tool_addr};
        fid     = {item.id_page_byte, item.pdu_format, item.pdu_specific, item.source_addr};
        grp64   = (item.mode == jtp_pkg::MODE_START) ? 64'(item.pgn) : 64'(wanted_reg);
        ctl     = item.rx_data[7:0];
        np      = item.rx_data[31:24];
        seq     = item.rx_data[7:0];
        ann_grp = {item.rx_data[56], item.rx_data[55:40]};
        own_grp = {item.id_page_byte[0], item.pdu_format, item.pdu_specific};
        ann_mod = mod7(item.rx_data[23:8]);
        tick_inc = (tick_reg != 16'hFFFF) ? tick_reg + 16'd1 : tick_reg;
        fin     = (seq == pkt_total_reg);
        n_bytes = fin ? last_cnt_reg : 3'd7;
        chunk   = '0;
        for (int i = 0; i < 7; i++)
        begin
            if (3'(i) < n_bytes)
            begin
                chunk[8*i +: 8] = item.rx_data[8*(i+1) +: 8];
            end
        end

        req_res = '{kind: jtp_pkg::KIND_TX,
                    frame_id: {jtp_pkg::ID_PRIO_REQ, jtp_pkg::PF_REQ,
                               cfg.ecu_addr, cfg.tool_addr},
                    frame_data: grp64, byte_count: 3'd0};
        cts_res = '{kind: jtp_pkg::KIND_TX, frame_id: cm_id,
                    frame_data: {6'd0, wanted_reg, 16'hFFFF, 8'h01, np, jtp_pkg::CTL_CTS},
                    byte_count: 3'd0};
        eom_res = '{kind: jtp_pkg::KIND_TX, frame_id: cm_id,
                    frame_data: {6'd0, wanted_reg, 8'hFF, pkt_total_reg, total_reg,
                                 jtp_pkg::CTL_EOM},
                    byte_count: 3'd0};
        chunk_res = '{kind: jtp_pkg::KIND_CHUNK, frame_id: 32'd0, frame_data: chunk,
                      byte_count: n_bytes};
        done_res  = '{kind: jtp_pkg::KIND_DONE, frame_id: 32'd0, frame_data: 64'd0,
                      byte_count: 3'd0};
        tmo_res   = '{kind: jtp_pkg::KIND_TIMEOUT, frame_id: 32'd0, frame_data: 64'd0,
                      byte_count: 3'd0};
        err_res   = '{kind: jtp_pkg::KIND_SEQ_ERR, frame_id: 32'd0, frame_data: 64'd0,
                      byte_count: 3'd0};
        frame_res = '{kind: jtp_pkg::KIND_FRAME, frame_id: fid, frame_data: item.rx_data,
                      byte_count: 3'd0};

        phase_next     = phase_reg;
        wanted_next    = wanted_reg;
        total_next     = total_reg;
        pkt_total_next = pkt_total_reg;
        next_seq_next  = next_seq_reg;
        req_sent_next  = req_sent_reg;
        tick_next      = tick_reg;
        last_cnt_next  = last_cnt_reg;
        bundle         = '0;

        case (item.mode)
            jtp_pkg::MODE_START:
            begin
                wanted_next    = item.pgn;
                total_next     = 16'd0;
                pkt_total_next = 8'd0;
                next_seq_next  = 8'd1;
                req_sent_next  = 1'b0;
                tick_next      = 16'd0;
                phase_next     = PH_WAIT;
                if (!cfg.listen_first)
                begin
                    bundle.res[0] = req_res;
                    bundle.cnt    = 2'd1;
                    req_sent_next = 1'b1;
                end
            end
            jtp_pkg::MODE_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.timeout_ticks)
                    begin
                        bundle.cnt = 2'd1;
                        if (!req_sent_reg)
                        begin
                            bundle.res[0] = req_res;
                            req_sent_next = 1'b1;
                            phase_next    = PH_WAIT;
                            tick_next     = 16'd0;
                            next_seq_next = 8'd1;
                        end
                        else
                        begin
                            bundle.res[0] = tmo_res;
                            phase_next    = PH_IDLE;
                        end
                    end
                end
            end
            jtp_pkg::MODE_FRAME:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (item.pdu_format == jtp_pkg::PF_ACK)
                    begin
                        bundle.res[0] = frame_res;
                        bundle.cnt    = 2'd1;
                        phase_next    = PH_IDLE;
                    end
                    else if (item.pdu_format == jtp_pkg::PF_CM)
                    begin
                        if ({1'b0, ann_grp} == wanted_reg && np != 8'd0
                            && (ctl == jtp_pkg::CTL_BAM || ctl == jtp_pkg::CTL_RTS))
                        begin
                            total_next     = item.rx_data[23:8];
                            pkt_total_next = np;
                            next_seq_next  = 8'd1;
                            tick_next      = 16'd0;
                            last_cnt_next  = (ann_mod == 3'd0) ? 3'd7 : ann_mod;
                            if (ctl == jtp_pkg::CTL_BAM)
                            begin
                                phase_next = PH_BAM;
                            end
                            else
                            begin
                                phase_next    = PH_RTS;
                                bundle.res[0] = cts_res;
                                bundle.cnt    = 2'd1;
                            end
                        end
                    end
                    else if ({1'b0, own_grp} == wanted_reg)
                    begin
                        bundle.res[0] = frame_res;
                        bundle.cnt    = 2'd1;
                        phase_next    = PH_IDLE;
                    end
                end
                else if ((phase_reg == PH_BAM || phase_reg == PH_RTS)
                         && item.pdu_format == jtp_pkg::PF_DT)
                begin
                    if (seq == next_seq_reg)
                    begin
                        bundle.res[0] = chunk_res;
                        bundle.cnt    = 2'd1;
                        next_seq_next = next_seq_reg + 8'd1;
                        tick_next     = 16'd0;
                        if (fin)
                        begin
                            phase_next = PH_IDLE;
                            if (phase_reg == PH_RTS)
                            begin
                                bundle.res[1] = eom_res;
                                bundle.res[2] = done_res;
                                bundle.cnt    = 2'd3;
                            end
                            else
                            begin
                                bundle.res[1] = done_res;
                                bundle.cnt    = 2'd2;
                            end
                        end
                    end
                    else if (seq > next_seq_reg)
                    begin
                        bundle.res[0] = err_res;
                        bundle.cnt    = 2'd1;
                        phase_next    = PH_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wanted_reg    <= '0;
            total_reg     <= '0;
            pkt_total_reg <= '0;
            next_seq_reg  <= 8'd1;
            req_sent_reg  <= 1'b0;
            tick_reg      <= '0;
            last_cnt_reg  <= 3'd7;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            wanted_reg    <= wanted_next;
            total_reg     <= total_next;
            pkt_total_reg <= pkt_total_next;
            next_seq_reg  <= next_seq_next;
            req_sent_reg  <= req_sent_next;
            tick_reg      <= tick_next;
            last_cnt_reg  <= last_cnt_next;
        end
    end

endmodule
